### rtl/crpt_pkg.sv
// package: types, codes and sizes shared by the channel range patch table
`default_nettype none
package crpt_pkg;

	localparam int MAX_FIXTURES = 32;
	localparam int IDX_W        = $clog2(MAX_FIXTURES);
	localparam int CNT_W        = $clog2(MAX_FIXTURES + 1);
	localparam int CH_W         = 10;
	localparam int ID_W         = 16;
	localparam int STAT_W       = 3;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 10;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_CHANNEL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHANNEL = 1'd1;

	localparam logic [CH_W-1:0] MIN_CHANNEL_RST = 10'd0;
	localparam logic [CH_W-1:0] MAX_CHANNEL_RST = 10'd512;

	typedef enum logic [1:0] {
		KIND_PATCH   = 2'd0,
		KIND_UNPATCH = 2'd1,
		KIND_LOOKUP  = 2'd2,
		KIND_NONE    = 2'd3
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 3'd0,
		STAT_IN_USE    = 3'd1,
		STAT_BOUNDS    = 3'd2,
		STAT_NOT_FOUND = 3'd3,
		STAT_FULL      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [CH_W-1:0] start;
		logic [CH_W-1:0] stop;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

### rtl/crpt_if.sv
// request and response channel interfaces of the channel range patch table
`default_nettype none
interface crpt_req_if import crpt_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [1:0]      kind;
	logic [ID_W-1:0] fixture_id;
	logic [CH_W-1:0] ch_start;
	logic [CH_W-1:0] ch_stop;

	modport source (output valid, kind, fixture_id, ch_start, ch_stop, input ready);
	modport sink (input valid, kind, fixture_id, ch_start, ch_stop, output ready);
endinterface

interface crpt_rsp_if import crpt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [CH_W-1:0]   found_start;
	logic [CH_W-1:0]   found_stop;

	modport source (output valid, status, found_start, found_stop, input ready);
	modport sink (input valid, status, found_start, found_stop, output ready);
endinterface
`default_nettype wire

### rtl/crpt_ram.sv
// generic ram: one write port, one read port with registered read data
`default_nettype none
module crpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### rtl/channel_range_patch_table_core.sv
// top level: fixture table with range overlap check, scanned by one shared compare unit
// patch and lookup scan the stored entries from accept to result, stopping at a hit;
//   unpatch scans to the entry, then moves the later entries down one slot
// an out-of-bounds patch or an unused kind skips the scan and goes straight to the result
// one transaction at a time, next accept in the cycle after the result loads
// reset (arst_n low): table emptied through the fill count, min_channel 0, max_channel 512
`default_nettype none
module channel_range_patch_table_core import crpt_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	crpt_req_if.sink                   req,
	crpt_rsp_if.source                 rsp
);

	// control state
	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;          // stored entries, always the lowest slots
	logic [CNT_W-1:0]  idx_q, idx_d;          // next ram read address
	logic              chk_q, chk_d;          // read data of last cycle is to be checked
	logic [CNT_W-1:0]  chk_idx_q, chk_idx_d;  // slot that read data belongs to
	logic              out_valid_q;
	logic              load_out;

	// configuration
	logic [CH_W-1:0]   min_q;
	logic [CH_W-1:0]   max_q;

	// held transaction and its result
	kind_t             kind_q, kind_d;
	logic [ID_W-1:0]   id_q, id_d;
	logic [CH_W-1:0]   start_q, start_d;
	logic [CH_W-1:0]   stop_q, stop_d;
	status_t           res_status_q, res_status_d;
	logic [CH_W-1:0]   res_fs_q, res_fs_d;
	logic [CH_W-1:0]   res_fp_q, res_fp_d;
	logic [STAT_W-1:0] out_status_q;
	logic [CH_W-1:0]   out_fs_q;
	logic [CH_W-1:0]   out_fp_q;

	// table ram
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [IDX_W-1:0]  ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t            rd_ent;
	entry_t            new_ent;

	// shared compare unit
	logic              issue;
	logic              hit;
	logic              bounds_ok;
	logic [CNT_W-1:0]  wr_back;

	crpt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_FIXTURES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_ent    = entry_t'(ram_rdata);
	assign new_ent   = '{id: id_q, start: start_q, stop: stop_q};
	assign ram_raddr = idx_q[IDX_W-1:0];
	assign wr_back   = chk_idx_q - 1'b1;

	// one more slot to read while idx is below the fill count
	assign issue = (idx_q < cnt_q);

	// patch looks for an overlapping range, the others for the id
	assign hit = (kind_q == KIND_PATCH) ?
		((start_q <= rd_ent.stop) && (rd_ent.start <= stop_q)) :
		(rd_ent.id == id_q);

	assign bounds_ok = (req.ch_start > min_q) && (req.ch_stop <= max_q);

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.found_start = out_fs_q;
	assign rsp.found_stop  = out_fp_q;

	// next state and datapath control
	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		idx_d        = idx_q;
		chk_d        = 1'b0;
		chk_idx_d    = idx_q;
		kind_d       = kind_q;
		id_d         = id_q;
		start_d      = start_q;
		stop_d       = stop_q;
		res_status_d = res_status_q;
		res_fs_d     = res_fs_q;
		res_fp_d     = res_fp_q;
		ram_we       = 1'b0;
		ram_waddr    = cnt_q[IDX_W-1:0];
		ram_wdata    = new_ent;
		load_out     = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					kind_d       = kind_t'(req.kind);
					id_d         = req.fixture_id;
					start_d      = req.ch_start;
					stop_d       = req.ch_stop;
					idx_d        = '0;
					res_status_d = STAT_OK;
					res_fs_d     = '0;
					res_fp_d     = '0;
					if (kind_t'(req.kind) == KIND_PATCH && !bounds_ok) begin
						res_status_d = STAT_BOUNDS;
						state_d      = S_DONE;
					end else if (kind_t'(req.kind) == KIND_NONE) begin
						state_d = S_DONE;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				// read slot idx while checking the slot read last cycle
				chk_d = issue;
				if (issue) begin
					idx_d = idx_q + 1'b1;
				end
				if (chk_q && hit) begin
					chk_d = 1'b0;
					case (kind_q)
						KIND_PATCH: begin
							res_status_d = STAT_IN_USE;
							state_d      = S_DONE;
						end
						KIND_UNPATCH: begin
							// close the gap: slot k+1 moves to slot k
							idx_d   = chk_idx_q + 1'b1;
							state_d = S_SHIFT;
						end
						default: begin
							res_fs_d = rd_ent.start;
							res_fp_d = rd_ent.stop;
							state_d  = S_DONE;
						end
					endcase
				end else if (!chk_q && !issue) begin
					// whole table seen without a hit
					if (kind_q == KIND_PATCH) begin
						if (cnt_q == CNT_W'(MAX_FIXTURES)) begin
							res_status_d = STAT_FULL;
						end else begin
							ram_we = 1'b1;
							cnt_d  = cnt_q + 1'b1;
						end
					end else begin
						res_status_d = STAT_NOT_FOUND;
					end
					state_d = S_DONE;
				end
			end
			S_SHIFT: begin
				chk_d = issue;
				if (issue) begin
					idx_d = idx_q + 1'b1;
				end
				if (chk_q) begin
					ram_we    = 1'b1;
					ram_waddr = wr_back[IDX_W-1:0];
					ram_wdata = ram_rdata;
				end else if (!issue) begin
					cnt_d   = cnt_q - 1'b1;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				// wait for the output register to free up
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			chk_q       <= 1'b0;
			out_valid_q <= 1'b0;
			min_q       <= MIN_CHANNEL_RST;
			max_q       <= MAX_CHANNEL_RST;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			chk_q   <= chk_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_MIN_CHANNEL: min_q <= cfg_data;
					CFG_MAX_CHANNEL: max_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		chk_idx_q    <= chk_idx_d;
		kind_q       <= kind_d;
		id_q         <= id_d;
		start_q      <= start_d;
		stop_q       <= stop_d;
		res_status_q <= res_status_d;
		res_fs_q     <= res_fs_d;
		res_fp_q     <= res_fp_d;
		if (load_out) begin
			out_status_q <= res_status_q;
			out_fs_q     <= res_fs_q;
			out_fp_q     <= res_fp_q;
		end
	end

`ifndef SYNTHESIS
	// fill count never exceeds the table depth
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_FIXTURES))
		else $error("fill count above table depth");

	// moving entries down only writes inside the stored prefix
	a_shift_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT && ram_we) |-> (wr_back < cnt_q))
		else $error("shift write outside stored entries");

	// fill count changes only at the end of a scan or a shift
	a_cnt_change: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt_q) |-> ($past(state_q) == S_SCAN || $past(state_q) == S_SHIFT))
		else $error("fill count changed outside scan or shift");

	// an accepted transaction keeps the block busy the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("accepted a second transaction while busy");
`endif

endmodule
`default_nettype wire
